/* rtl/bsr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_pkg
// Types and constants shared by the BMP stream to RGB565 decoder.
// ----------------------------------------------------------------------------
package bsr_pkg;

    // One byte of the incoming file.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_file;
    } byte_t;

    // One result: a pixel, an image-done report or an error.
    typedef struct packed {
        logic [1:0]  kind;
        logic [21:0] pixel_index;
        logic [15:0] pixel_rgb565;
        logic [7:0]  pixel_alpha;
        logic [11:0] image_width;
        logic [11:0] image_height;
        logic        alpha_used;
        logic [2:0]  error_code;
        logic        run_last;
    } result_t;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_PAD,
        PH_DONE,
        PH_FAIL
    } phase_t;

    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_SIGNATURE = 3'd0;
    localparam logic [2:0] ERR_HEADER    = 3'd1;
    localparam logic [2:0] ERR_FORMAT    = 3'd2;
    localparam logic [2:0] ERR_TRUNCATED = 3'd3;
    localparam logic [2:0] ERR_OFFSET    = 3'd4;

    // Header layout, byte positions from the start of the file.
    localparam logic [5:0] POS_SIG_B    = 6'd0;
    localparam logic [5:0] POS_SIG_M    = 6'd1;
    localparam logic [5:0] POS_OFFSET   = 6'd10;
    localparam logic [5:0] POS_HDR_SIZE = 6'd14;
    localparam logic [5:0] POS_WIDTH    = 6'd18;
    localparam logic [5:0] POS_HEIGHT   = 6'd22;
    localparam logic [5:0] POS_BPP      = 6'd28;
    localparam logic [5:0] POS_COMP     = 6'd30;
    localparam logic [5:0] POS_HDR_LAST = 6'd53;

    localparam logic [7:0]  SIG_B        = 8'h42;
    localparam logic [7:0]  SIG_M        = 8'h4D;
    localparam logic [31:0] HDR_BYTES    = 32'd54;
    localparam logic [31:0] MIN_HDR_SIZE = 32'd40;
    localparam logic [15:0] BPP_24       = 16'd24;
    localparam logic [15:0] BPP_32       = 16'd32;
    localparam logic [31:0] COMP_NONE    = 32'd0;
    localparam logic [31:0] COMP_FIELDS  = 32'd3;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    // Hard limit on width and height, and the reset value of the register.
    localparam logic [11:0] MAX_DIM       = 12'd2048;
    localparam logic [11:0] MAX_DIM_RESET = 12'd2048;

    // Configuration register map.
    localparam int          PADDR_W           = 3;
    localparam logic        REG_MAX_DIMENSION = 1'b0;

    localparam int QUEUE_DEPTH = 4;

endpackage

/* rtl/bsr_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_queue
// Small result queue: takes up to two results per cycle, sends one unless result_stall is set.
// ----------------------------------------------------------------------------
module bsr_queue #(
    parameter int DEPTH = bsr_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  bsr_pkg::result_t  push_data [2],
    output logic              almost_full,
    output logic              result_valid,
    input  logic              result_stall,
    output bsr_pkg::result_t  result_data
);
    import bsr_pkg::*;

    // DEPTH must be a power of two, at least two; the queue does not check it.
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    result_t            entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               pop;

    assign result_valid = (count_reg != '0);
    assign result_data  = entry_reg[rd_ptr_reg];
    assign pop          = result_valid && !result_stall;
    // Room must remain for the largest burst one byte can cause.
    assign almost_full  = (count_reg > CNT_W'(DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_cnt) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push_data[0];
        end
        if (push_cnt == 2'd2)
        begin
            entry_reg[wr_ptr_reg + PTR_W'(1)] <= push_data[1];
        end
    end

endmodule

/* rtl/bsr_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_decode
// Byte-wise BMP parser: header capture and checks, offset skip, pixel
// assembly, row padding and end-of-image detection.
// ----------------------------------------------------------------------------
module bsr_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  bsr_pkg::byte_t    byte_data,
    input  logic [11:0]       max_dimension,
    output logic [1:0]        push_cnt,
    output bsr_pkg::result_t  push_data [2]
);
    import bsr_pkg::*;

    phase_t       phase_reg,          phase_next;
    logic [31:0]  byte_position_reg,  byte_position_next;
    logic [31:0]  data_offset_reg,    data_offset_next;
    logic [31:0]  header_size_reg,    header_size_next;
    logic [31:0]  compression_reg,    compression_next;
    logic [31:0]  raw_width_reg,      raw_width_next;
    logic [31:0]  raw_height_reg,     raw_height_next;
    logic [15:0]  bpp_reg,            bpp_next;
    logic         bottom_up_reg,      bottom_up_next;
    logic [11:0]  row_reg,            row_next;
    logic [11:0]  column_reg,         column_next;
    logic [1:0]   byte_in_pixel_reg,  byte_in_pixel_next;
    logic [1:0]   padding_left_reg,   padding_left_next;
    logic [23:0]  partial_reg,        partial_next;
    logic         alpha_seen_reg,     alpha_seen_next;
    logic [11:0]  img_w_reg,          img_w_next;
    logic [11:0]  img_h_reg,          img_h_next;

    logic [7:0]   b;
    logic [5:0]   p6;
    logic [11:0]  limit;
    logic [31:0]  h_mag;
    logic         size_bad;
    logic         fmt_bad;
    logic         off_bad;
    logic         is32;
    logic [1:0]   last_byte;
    logic [23:0]  merged;
    logic [7:0]   alpha;
    logic [11:0]  dy;
    logic [23:0]  prod;
    logic [12:0]  col_inc;
    logic [12:0]  row_inc;
    logic         row_last;
    logic [1:0]   pad_dec;
    result_t      pixel_res;
    result_t      done_res;
    result_t      fail_res;
    result_t      trunc_res;
    result_t      first_res;
    logic         first_valid;
    logic         done_after_pixel;
    logic         trunc_valid;

    assign b         = byte_data.data_byte;
    assign p6        = byte_position_reg[5:0];
    assign limit     = (max_dimension < MAX_DIM) ? max_dimension : MAX_DIM;
    assign h_mag     = raw_height_reg[31] ? (32'd0 - raw_height_reg) : raw_height_reg;
    assign size_bad  = (header_size_reg < MIN_HDR_SIZE) || (raw_width_reg == 32'd0) ||
                       raw_width_reg[31] || (h_mag == 32'd0) ||
                       (raw_width_reg > {20'd0, limit}) || (h_mag > {20'd0, limit});
    assign fmt_bad   = ((bpp_reg != BPP_24) && (bpp_reg != BPP_32)) ||
                       ((compression_reg != COMP_NONE) && (compression_reg != COMP_FIELDS));
    assign off_bad   = (data_offset_reg < HDR_BYTES);
    assign is32      = (bpp_reg == BPP_32);
    assign last_byte = is32 ? 2'd3 : 2'd2;

    // The incoming byte merged into the blue, green, red accumulator.
    always_comb
    begin
        merged = partial_reg;
        case (byte_in_pixel_reg)
            2'd0:    merged[7:0]   = b;
            2'd1:    merged[15:8]  = b;
            2'd2:    merged[23:16] = b;
            default: merged = partial_reg;
        endcase
    end

    assign alpha    = is32 ? b : ALPHA_OPAQUE;
    assign dy       = bottom_up_reg ? (img_h_reg - 12'd1 - row_reg) : row_reg;
    assign prod     = 24'(dy) * 24'(img_w_reg);
    assign col_inc  = {1'b0, column_reg} + 13'd1;
    assign row_inc  = {1'b0, row_reg} + 13'd1;
    assign row_last = (row_inc >= {1'b0, img_h_reg});
    assign pad_dec  = padding_left_reg - 2'd1;

    always_comb
    begin
        pixel_res              = '0;
        pixel_res.kind         = KIND_PIXEL;
        pixel_res.pixel_index  = 22'(prod + 24'(column_reg));
        pixel_res.pixel_rgb565 = {merged[23:19], merged[15:10], merged[7:3]};
        pixel_res.pixel_alpha  = alpha;

        // Done right after the final pixel also counts that pixel's alpha, and
        // must not see the clear that an end of file on the same byte causes.
        done_res               = '0;
        done_res.kind          = KIND_DONE;
        done_res.image_width   = img_w_reg;
        done_res.image_height  = img_h_reg;
        done_res.alpha_used    = alpha_seen_reg ||
                                 ((phase_reg == PH_PIXELS) && (alpha != ALPHA_OPAQUE));

        trunc_res              = '0;
        trunc_res.kind         = KIND_ERROR;
        trunc_res.error_code   = ERR_TRUNCATED;
    end

    always_comb
    begin
        phase_next         = phase_reg;
        byte_position_next = byte_position_reg;
        data_offset_next   = data_offset_reg;
        header_size_next   = header_size_reg;
        compression_next   = compression_reg;
        raw_width_next     = raw_width_reg;
        raw_height_next    = raw_height_reg;
        bpp_next           = bpp_reg;
        bottom_up_next     = bottom_up_reg;
        row_next           = row_reg;
        column_next        = column_reg;
        byte_in_pixel_next = byte_in_pixel_reg;
        padding_left_next  = padding_left_reg;
        partial_next       = partial_reg;
        alpha_seen_next    = alpha_seen_reg;
        img_w_next         = img_w_reg;
        img_h_next         = img_h_reg;
        fail_res           = '0;
        fail_res.kind      = KIND_ERROR;
        first_res          = '0;
        first_valid        = 1'b0;
        done_after_pixel   = 1'b0;
        trunc_valid        = 1'b0;

        if (accept)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (((p6 == POS_SIG_B) && (b != SIG_B)) ||
                        ((p6 == POS_SIG_M) && (b != SIG_M)))
                    begin
                        fail_res.error_code = ERR_SIGNATURE;
                        first_res   = fail_res;
                        first_valid = 1'b1;
                        phase_next  = PH_FAIL;
                    end
                    else
                    begin
                        // Little-endian fields, each byte written once.
                        if (p6 >= POS_OFFSET && p6 <= POS_OFFSET + 6'd3)
                        begin
                            data_offset_next = data_offset_reg |
                                (32'(b) << {2'(p6 - POS_OFFSET), 3'b000});
                        end
                        else if (p6 >= POS_HDR_SIZE && p6 <= POS_HDR_SIZE + 6'd3)
                        begin
                            header_size_next = header_size_reg |
                                (32'(b) << {2'(p6 - POS_HDR_SIZE), 3'b000});
                        end
                        else if (p6 >= POS_WIDTH && p6 <= POS_WIDTH + 6'd3)
                        begin
                            raw_width_next = raw_width_reg |
                                (32'(b) << {2'(p6 - POS_WIDTH), 3'b000});
                        end
                        else if (p6 >= POS_HEIGHT && p6 <= POS_HEIGHT + 6'd3)
                        begin
                            raw_height_next = raw_height_reg |
                                (32'(b) << {2'(p6 - POS_HEIGHT), 3'b000});
                        end
                        else if (p6 >= POS_BPP && p6 <= POS_BPP + 6'd1)
                        begin
                            bpp_next = bpp_reg |
                                (16'(b) << {1'(p6 - POS_BPP), 3'b000});
                        end
                        else if (p6 >= POS_COMP && p6 <= POS_COMP + 6'd3)
                        begin
                            compression_next = compression_reg |
                                (32'(b) << {2'(p6 - POS_COMP), 3'b000});
                        end
                        byte_position_next = byte_position_reg + 32'd1;
                        if (p6 == POS_HDR_LAST)
                        begin
                            // A negative height marks a top-down image.
                            if (raw_height_reg[31])
                            begin
                                bottom_up_next = 1'b0;
                            end
                            if (size_bad)
                            begin
                                fail_res.error_code = ERR_HEADER;
                                first_res   = fail_res;
                                first_valid = 1'b1;
                                phase_next  = PH_FAIL;
                            end
                            else if (fmt_bad)
                            begin
                                fail_res.error_code = ERR_FORMAT;
                                first_res   = fail_res;
                                first_valid = 1'b1;
                                phase_next  = PH_FAIL;
                            end
                            else if (off_bad)
                            begin
                                fail_res.error_code = ERR_OFFSET;
                                first_res   = fail_res;
                                first_valid = 1'b1;
                                phase_next  = PH_FAIL;
                            end
                            else
                            begin
                                img_w_next = raw_width_reg[11:0];
                                img_h_next = h_mag[11:0];
                                phase_next = (data_offset_reg == HDR_BYTES) ? PH_PIXELS
                                                                            : PH_SKIP;
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                    byte_position_next = byte_position_reg + 32'd1;
                    if (byte_position_next == data_offset_reg)
                    begin
                        phase_next = PH_PIXELS;
                    end
                end
                PH_PIXELS:
                begin
                    if (byte_in_pixel_reg != last_byte)
                    begin
                        partial_next       = merged;
                        byte_in_pixel_next = byte_in_pixel_reg + 2'd1;
                    end
                    else
                    begin
                        if (alpha != ALPHA_OPAQUE)
                        begin
                            alpha_seen_next = 1'b1;
                        end
                        first_res          = pixel_res;
                        first_valid        = 1'b1;
                        byte_in_pixel_next = 2'd0;
                        partial_next       = '0;
                        column_next        = col_inc[11:0];
                        if (col_inc >= {1'b0, img_w_reg})
                        begin
                            // Rows of 3-byte pixels pad by width mod 4.
                            if (is32 || img_w_reg[1:0] == 2'd0)
                            begin
                                column_next = '0;
                                row_next    = row_inc[11:0];
                                if (row_last)
                                begin
                                    done_after_pixel = 1'b1;
                                    phase_next       = PH_DONE;
                                end
                            end
                            else
                            begin
                                padding_left_next = img_w_reg[1:0];
                                phase_next        = PH_PAD;
                            end
                        end
                    end
                end
                PH_PAD:
                begin
                    padding_left_next = pad_dec;
                    if (pad_dec == 2'd0)
                    begin
                        column_next = '0;
                        row_next    = row_inc[11:0];
                        if (row_last)
                        begin
                            first_res   = done_res;
                            first_valid = 1'b1;
                            phase_next  = PH_DONE;
                        end
                        else
                        begin
                            phase_next = PH_PIXELS;
                        end
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase

            if (byte_data.end_of_file)
            begin
                trunc_valid = (phase_next == PH_HEADER) || (phase_next == PH_SKIP) ||
                              (phase_next == PH_PIXELS) || (phase_next == PH_PAD);
                phase_next         = PH_HEADER;
                byte_position_next = '0;
                data_offset_next   = '0;
                header_size_next   = '0;
                compression_next   = '0;
                raw_width_next     = '0;
                raw_height_next    = '0;
                bpp_next           = '0;
                bottom_up_next     = 1'b1;
                row_next           = '0;
                column_next        = '0;
                byte_in_pixel_next = '0;
                padding_left_next  = '0;
                partial_next       = '0;
                alpha_seen_next    = 1'b0;
                img_w_next         = '0;
                img_h_next         = '0;
            end
        end
    end

    // Order of results: the primary one, then done or a truncation error.
    always_comb
    begin
        push_data[0] = first_valid ? first_res : trunc_res;
        push_data[1] = done_after_pixel ? done_res : trunc_res;
        if (first_valid && (done_after_pixel || trunc_valid))
        begin
            push_cnt = 2'd2;
        end
        else if (first_valid || trunc_valid)
        begin
            push_cnt = 2'd1;
        end
        else
        begin
            push_cnt = 2'd0;
        end
        push_data[0].run_last = (push_cnt == 2'd1);
        push_data[1].run_last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HEADER;
            byte_position_reg <= '0;
            data_offset_reg   <= '0;
            header_size_reg   <= '0;
            compression_reg   <= '0;
            raw_width_reg     <= '0;
            raw_height_reg    <= '0;
            bpp_reg           <= '0;
            bottom_up_reg     <= 1'b1;
            row_reg           <= '0;
            column_reg        <= '0;
            byte_in_pixel_reg <= '0;
            padding_left_reg  <= '0;
            partial_reg       <= '0;
            alpha_seen_reg    <= 1'b0;
            img_w_reg         <= '0;
            img_h_reg         <= '0;
        end
        else
        begin
            phase_reg         <= phase_next;
            byte_position_reg <= byte_position_next;
            data_offset_reg   <= data_offset_next;
            header_size_reg   <= header_size_next;
            compression_reg   <= compression_next;
            raw_width_reg     <= raw_width_next;
            raw_height_reg    <= raw_height_next;
            bpp_reg           <= bpp_next;
            bottom_up_reg     <= bottom_up_next;
            row_reg           <= row_next;
            column_reg        <= column_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            padding_left_reg  <= padding_left_next;
            partial_reg       <= partial_next;
            alpha_seen_reg    <= alpha_seen_next;
            img_w_reg         <= img_w_next;
            img_h_reg         <= img_h_next;
        end
    end

endmodule

/* rtl/bmp_stream_to_rgb565_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmp_stream_to_rgb565_decoder
// Streaming decoder for 24- and 32-bit BMP files to RGB565 pixels with alpha.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  -------   ---------  ------------------------  -------------------------
//  byte      in         byte_valid / byte_stall   byte_data (byte_t)
//  result    out        result_valid / result_stall  result_data (result_t)
//  config    in         APB write/read            max_dimension at 0x0
//
//  Each byte is decoded in the cycle it is accepted; one byte per cycle while byte_stall is low.
//  A byte causes at most two results, written into a four-entry result queue
//  whose head drives result_data; each result is registered into the queue.
//  byte_stall rises when the queue has fewer than two free entries, so a
//  stalled result side holds the byte side once the queue fills.
//  Reset clears the parser to wait for a new header and max_dimension to 2048.
//
module bmp_stream_to_rgb565_decoder #(
    parameter int QUEUE_DEPTH = bsr_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_valid,
    output logic                         byte_stall,
    input  bsr_pkg::byte_t               byte_data,
    output logic                         result_valid,
    input  logic                         result_stall,
    output bsr_pkg::result_t             result_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bsr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import bsr_pkg::*;

    logic [11:0]  max_dimension_reg;
    logic [11:0]  max_dimension_next;
    logic         accept;
    logic         almost_full;
    logic [1:0]   push_cnt;
    result_t      push_data [2];

    assign pready     = 1'b1;
    assign byte_stall = almost_full;
    assign accept     = byte_valid && !byte_stall;

    always_comb
    begin
        max_dimension_next = max_dimension_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == REG_MAX_DIMENSION))
        begin
            max_dimension_next = pwdata[11:0];
        end
        prdata = (paddr[2] == REG_MAX_DIMENSION) ? {20'd0, max_dimension_reg} : 32'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_dimension_reg <= MAX_DIM_RESET;
        end
        else
        begin
            max_dimension_reg <= max_dimension_next;
        end
    end

    bsr_decode u_decode (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .byte_data     (byte_data),
        .max_dimension (max_dimension_reg),
        .push_cnt      (push_cnt),
        .push_data     (push_data)
    );

    bsr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_cnt     (push_cnt),
        .push_data    (push_data),
        .almost_full  (almost_full),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

endmodule

/* rtl/bsr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsr_checker
// Port-level checks for the BMP stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bsr_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         byte_valid,
    input  logic                         byte_stall,
    input  bsr_pkg::byte_t               byte_data,
    input  logic                         result_valid,
    input  logic                         result_stall,
    input  bsr_pkg::result_t             result_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bsr_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    input  logic [31:0]                  prdata,
    input  logic                         pready
);
    import bsr_pkg::*;

    // A stalled transaction keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_data))
    else $error("result changed while stalled");

    // Done and errors always close the run of results for their byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.kind != KIND_PIXEL) |-> result_data.run_last)
    else $error("done or error not marked as last result");

    // Pixels carry no size, flag or error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result_data.kind == KIND_PIXEL) |->
            (result_data.image_width == 12'd0) && (result_data.image_height == 12'd0) &&
            !result_data.alpha_used && (result_data.error_code == 3'd0))
    else $error("pixel result carries done or error fields");

    // A written limit reads back on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[2] == REG_MAX_DIMENSION) |=>
            (paddr[2] != REG_MAX_DIMENSION) || (prdata[11:0] == $past(pwdata[11:0])))
    else $error("max_dimension readback mismatch");

endmodule

bind bmp_stream_to_rgb565_decoder bsr_checker u_checker (.*);
